[hw/rtl/dtw_length_normalized_core_defines.svh]
// Assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef DTW_LENGTH_NORMALIZED_CORE_DEFINES_SVH
`define DTW_LENGTH_NORMALIZED_CORE_DEFINES_SVH

`define DTWLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define DTWLN_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DTWLN_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hw/rtl/dtw_ln_pkg.sv]
package dtw_ln_pkg;

  localparam int unsigned MaxRowsDef = 256;
  localparam int unsigned MaxColsDef = 1024;

  localparam int unsigned DistW     = 16;
  localparam int unsigned CostW     = 32;
  localparam int unsigned LenW      = 16;
  localparam int unsigned RowCountW = 9;
  localparam int unsigned ColCountW = 11;
  localparam int unsigned DiagStepW = 4;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 11;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned DirLsb    = 0;
  localparam int unsigned CostLsb   = 2;
  localparam int unsigned LenLsb    = 34;
  localparam int unsigned NormLsb   = 50;
  localparam int unsigned OutPadW   = 6;
  localparam int unsigned OutTdataW = 88;

  localparam logic [CostW-1:0] CostInf = '1;
  localparam logic [LenW-1:0]  LenMax  = '1;
  localparam logic [LenW-1:0]  LenOne  = LenW'(1);

  localparam logic [RowCountW-1:0] RowCountRst = RowCountW'(1);
  localparam logic [ColCountW-1:0] ColCountRst = ColCountW'(1);
  localparam logic [DiagStepW-1:0] DiagStepRst = DiagStepW'(2);
  localparam logic                 TieModeRst  = 1'b1;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_LEFT = 2'd2
  } dir_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1,
    CFG_DIAG_STEP = 2'd2,
    CFG_TIE_MODE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hw/rtl/dtw_ln_row_mem.sv]
module dtw_ln_row_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 48,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dtw_ln_div.sv]
module dtw_ln_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      ack_i,
  input  logic [dtw_ln_pkg::CostW-1:0] dividend_i,
  input  logic [dtw_ln_pkg::LenW-1:0]  divisor_i,
  output dtw_ln_pkg::div_status_t   status_o,
  output logic [dtw_ln_pkg::CostW-1:0] quot_o
);
  import dtw_ln_pkg::*;

  localparam int unsigned StepW = $clog2(CostW);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  div_state_e       state_q;
  logic [StepW-1:0] cnt_q;
  logic [LenW-1:0]  rem_q;
  logic [LenW-1:0]  dsr_q;
  logic [CostW-1:0] quo_q;

  logic [LenW:0] shifted;
  logic [LenW:0] diff;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[CostW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        DIV_IDLE: begin
          if (start_i) begin
            quo_q   <= dividend_i;
            dsr_q   <= divisor_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          rem_q <= ge ? diff[LenW-1:0] : shifted[LenW-1:0];
          quo_q <= {quo_q[CostW-2:0], ge};
          cnt_q <= cnt_q + StepW'(1);
          if (cnt_q == StepW'(CostW - 1)) begin
            state_q <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (ack_i) begin
            state_q <= DIV_IDLE;
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  assign status_o.busy = (state_q != DIV_IDLE);
  assign status_o.done = (state_q == DIV_DONE);
  assign quot_o        = quo_q;

endmodule

[hw/rtl/dtw_length_normalized_core.sv]
// Path: an ordinary cell is registered in stage 2 and then in the output register; the last
// cell of the matrix then waits for the 32-step restoring divider.
// Throughput: one cell per cycle while the output is not stalled, bounded by the single row-memory
// read and write port; input is held off while the divider runs or holds its result.
// Reset: configuration returns to defaults and a fill count marks the row memory
// empty, so no clearing pass is needed and the block is ready at once.
module dtw_length_normalized_core #(
  parameter int unsigned MAX_ROWS = dtw_ln_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = dtw_ln_pkg::MaxColsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dtw_ln_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [dtw_ln_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] dist_value
  input  logic [dtw_ln_pkg::InTdataW-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [1:0] direction, [33:2] cell_cost, [49:34] cell_length, [81:50] normalized_cost
  output logic [dtw_ln_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // is_final
  output logic                             m_axis_tlast_o
);
  import dtw_ln_pkg::*;

  localparam int unsigned ColIdxW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowIdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned FillW   = $clog2(MAX_COLS + 1);
  localparam int unsigned CmpW    = ColIdxW + 1;
  localparam int unsigned WordW   = CostW + LenW;

  // configuration
  logic [RowCountW-1:0] row_count_q;
  logic [ColCountW-1:0] col_count_q;
  logic [DiagStepW-1:0] diag_step_q;
  logic                 tie_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountRst;
      col_count_q <= ColCountRst;
      diag_step_q <= DiagStepRst;
      tie_mode_q  <= TieModeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_ROW_COUNT: row_count_q <= cfg_wdata_i[RowCountW-1:0];
        CFG_COL_COUNT: col_count_q <= cfg_wdata_i[ColCountW-1:0];
        CFG_DIAG_STEP: diag_step_q <= cfg_wdata_i[DiagStepW-1:0];
        CFG_TIE_MODE:  tie_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // position and handshake
  logic [ColIdxW-1:0] col_idx_q;
  logic [RowIdxW-1:0] row_idx_q;
  logic [31:0]        rows_eff;
  logic [31:0]        cols_eff;
  logic               row_end;
  logic               mat_end;
  logic               in_acc;
  logic               out_free;
  logic               s2_fire;
  div_status_t        div_st;
  logic [CostW-1:0]   div_quot;

  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = 32'd1;
    end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end else begin
      rows_eff = 32'(row_count_q);
    end
    if (col_count_q == '0) begin
      cols_eff = 32'd1;
    end else if (32'(col_count_q) > 32'(MAX_COLS)) begin
      cols_eff = 32'(MAX_COLS);
    end else begin
      cols_eff = 32'(col_count_q);
    end
    row_end = (32'(col_idx_q) + 32'd1) >= cols_eff;
    mat_end = row_end && ((32'(row_idx_q) + 32'd1) >= rows_eff);
  end

  // stage 2 registers
  logic               s2_valid_q;
  logic [DistW-1:0]   s2_dist_q;
  logic [ColIdxW-1:0] s2_col_q;
  logic               s2_col0_q;
  logic               s2_row0_q;
  logic               s2_final_q;
  logic               s2_fwd_q;
  logic [WordW-1:0]   s2_fwd_word_q;

  logic [WordW-1:0]   mem_rdata;
  logic [WordW-1:0]   new_word;
  logic [FillW-1:0]   fill_q;
  logic [CostW-1:0]   left_cost_q;
  logic [LenW-1:0]    left_len_q;
  logic [CostW-1:0]   diag_cost_q;
  logic [LenW-1:0]    diag_len_q;

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign s2_fire         = s2_valid_q && !div_st.busy && out_free;
  assign s_axis_tready_o = !div_st.busy && (!s2_valid_q || s2_fire);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_idx_q  <= '0;
      row_idx_q  <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s2_valid_q <= 1'b1;
        if (mat_end) begin
          col_idx_q <= '0;
          row_idx_q <= '0;
        end else if (row_end) begin
          col_idx_q <= '0;
          row_idx_q <= row_idx_q + RowIdxW'(1);
        end else begin
          col_idx_q <= col_idx_q + ColIdxW'(1);
        end
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_dist_q     <= s_axis_tdata_i[DistW-1:0];
      s2_col_q      <= col_idx_q;
      s2_col0_q     <= (col_idx_q == '0);
      s2_row0_q     <= (row_idx_q == '0);
      s2_final_q    <= mat_end;
      s2_fwd_q      <= s2_fire && (s2_col_q == col_idx_q);
      s2_fwd_word_q <= new_word;
    end
  end

  dtw_ln_row_mem #(
    .Depth (MAX_COLS),
    .Width (WordW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (s2_fire),
    .waddr_i (s2_col_q),
    .wdata_i (new_word),
    .re_i    (in_acc),
    .raddr_i (col_idx_q),
    .rdata_o (mem_rdata)
  );

  // cell update
  logic [WordW-1:0] up_word;
  logic             up_valid;
  logic [CostW-1:0] up_cost;
  logic [LenW-1:0]  up_len;
  logic [CostW-1:0] dg_cost;
  logic [LenW-1:0]  dg_len;
  logic [CostW-1:0] lf_cost;
  logic [LenW-1:0]  lf_len;
  logic             take_up;
  dir_e             dir;
  logic [CostW-1:0] sel_cost;
  logic [LenW-1:0]  sel_len;
  logic [LenW:0]    len_sum;
  logic [CostW:0]   cost_sum;
  logic [CostW-1:0] new_cost;
  logic [LenW-1:0]  new_len;
  logic [CmpW-1:0]  col_next;

  always_comb begin
    up_word  = s2_fwd_q ? s2_fwd_word_q : mem_rdata;
    up_valid = CmpW'(s2_col_q) < CmpW'(fill_q);
    up_cost  = up_valid ? up_word[CostW-1:0] : CostInf;
    up_len   = up_valid ? up_word[WordW-1:CostW] : LenOne;
    dg_cost  = s2_col0_q ? (s2_row0_q ? '0 : CostInf) : diag_cost_q;
    dg_len   = s2_col0_q ? LenOne : diag_len_q;
    lf_cost  = s2_col0_q ? CostInf : left_cost_q;
    lf_len   = s2_col0_q ? LenOne : left_len_q;

    if (tie_mode_q) begin
      take_up = (up_cost <= lf_cost) && (up_cost <= dg_cost);
    end else begin
      take_up = (up_cost < lf_cost) && (up_cost < dg_cost);
    end

    if (take_up) begin
      dir      = DIR_UP;
      sel_cost = up_cost;
      len_sum  = {1'b0, up_len} + (LenW+1)'(1);
    end else if ((dg_cost <= lf_cost) && (dg_cost <= up_cost)) begin
      dir      = DIR_DIAG;
      sel_cost = dg_cost;
      len_sum  = {1'b0, dg_len} + (LenW+1)'(diag_step_q);
    end else begin
      dir      = DIR_LEFT;
      sel_cost = lf_cost;
      len_sum  = {1'b0, lf_len} + (LenW+1)'(1);
    end
    sel_len  = len_sum[LenW-1:0];
    new_len  = len_sum[LenW] ? LenMax : sel_len;
    cost_sum = {1'b0, sel_cost} + (CostW+1)'(s2_dist_q);
    new_cost = cost_sum[CostW] ? CostInf : cost_sum[CostW-1:0];
    new_word = {new_len, new_cost};
    col_next = CmpW'(s2_col_q) + CmpW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (s2_fire) begin
      if (s2_final_q) begin
        fill_q <= '0;
      end else if (col_next > CmpW'(fill_q)) begin
        fill_q <= FillW'(col_next);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      left_cost_q <= new_cost;
      left_len_q  <= new_len;
      diag_cost_q <= up_cost;
      diag_len_q  <= up_len;
    end
  end

  // final cell: cost / length
  dir_e             fin_dir_q;
  logic [CostW-1:0] fin_cost_q;
  logic [LenW-1:0]  fin_len_q;
  logic             div_start;
  logic             div_ack;

  assign div_start = s2_fire && s2_final_q;
  assign div_ack   = div_st.done && out_free;

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      fin_dir_q  <= dir;
      fin_cost_q <= new_cost;
      fin_len_q  <= new_len;
    end
  end

  dtw_ln_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .ack_i      (div_ack),
    .dividend_i (new_cost),
    .divisor_i  (new_len),
    .status_o   (div_st),
    .quot_o     (div_quot)
  );

  // output register
  logic             m_valid_q;
  dir_e             m_dir_q;
  logic [CostW-1:0] m_cost_q;
  logic [LenW-1:0]  m_len_q;
  logic             m_last_q;
  logic [CostW-1:0] m_norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((s2_fire && !s2_final_q) || div_ack) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && !s2_final_q) begin
      m_dir_q  <= dir;
      m_cost_q <= new_cost;
      m_len_q  <= new_len;
      m_last_q <= 1'b0;
      m_norm_q <= '0;
    end else if (div_ack) begin
      m_dir_q  <= fin_dir_q;
      m_cost_q <= fin_cost_q;
      m_len_q  <= fin_len_q;
      m_last_q <= 1'b1;
      m_norm_q <= div_quot;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {OutPadW'(0), m_norm_q, m_len_q, m_cost_q, m_dir_q};

endmodule

[hw/rtl/dtw_ln_checker.sv]
`include "dtw_length_normalized_core_defines.svh"

module dtw_ln_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             mon_tvalid_i,
  input logic                             mon_tready_i,
  input logic [dtw_ln_pkg::OutTdataW-1:0] mon_tdata_i,
  input logic                             mon_tlast_i
);
  import dtw_ln_pkg::*;

  `DTWLN_ASSERT_NEXT(a_out_hold, mon_tvalid_i && !mon_tready_i, mon_tvalid_i, "result dropped while stalled")
  `DTWLN_ASSERT_NEXT(a_out_stable, mon_tvalid_i && !mon_tready_i, $stable(mon_tdata_i) && $stable(mon_tlast_i), "stalled result changed")
  `DTWLN_ASSERT(a_norm_zero, mon_tvalid_i && !mon_tlast_i |-> mon_tdata_i[NormLsb +: CostW] == '0, "normalised cost set on a non-final cell")
  `DTWLN_ASSERT(a_dir_code, mon_tvalid_i |-> mon_tdata_i[DirLsb +: 2] != 2'd3, "bad direction code")

endmodule

bind dtw_length_normalized_core dtw_ln_checker u_dtw_ln_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .mon_tvalid_i (m_axis_tvalid_o),
  .mon_tready_i (m_axis_tready_i),
  .mon_tdata_i  (m_axis_tdata_o),
  .mon_tlast_i  (m_axis_tlast_o)
);

[tb/dtw_length_normalized_checker.sv]
module dtw_length_normalized_checker #(
  parameter int unsigned MAX_ROWS = dtw_ln_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = dtw_ln_pkg::MaxColsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dtw_ln_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [dtw_ln_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  // [15:0] dist_value
  input  logic [dtw_ln_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  // [1:0] direction, [33:2] cell_cost, [49:34] cell_length, [81:50] normalized_cost
  input  logic [dtw_ln_pkg::OutTdataW-1:0] m_axis_tdata_i,
  // is_final
  input  logic                             m_axis_tlast_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      cells_due_o
);
  import dtw_ln_pkg::*;

  typedef struct packed {
    dir_e             dir;
    logic [CostW-1:0] cost;
    logic [LenW-1:0]  len;
    logic             fin;
    logic [CostW-1:0] norm;
  } cell_t;

  logic [RowCountW-1:0] rows_reg;
  logic [ColCountW-1:0] cols_reg;
  logic [DiagStepW-1:0] diag_step;
  logic                 tie_up;

  logic [CostW-1:0] prev_cost_row [MAX_COLS+1];
  logic [LenW-1:0]  prev_len_row  [MAX_COLS+1];
  logic [CostW-1:0] left_c;
  logic [LenW-1:0]  left_l;
  logic [CostW-1:0] diag_c;
  logic [LenW-1:0]  diag_l;
  int unsigned      row_pos;
  int unsigned      col_pos;

  cell_t       cells_due [$];
  int unsigned misses;

  function automatic void new_matrix();
    for (int unsigned k = 0; k <= MAX_COLS; k++) begin
      prev_cost_row[k] = CostInf;
      prev_len_row[k]  = LenOne;
    end
    prev_cost_row[0] = '0;
    left_c  = CostInf;
    left_l  = LenOne;
    diag_c  = '0;
    diag_l  = LenOne;
    row_pos = 0;
    col_pos = 0;
  endfunction

  function automatic int unsigned fit_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [LenW-1:0] len_step(input logic [LenW-1:0] a,
                                                input logic [LenW-1:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LenW] ? LenMax : s[LenW-1:0];
  endfunction

  function automatic cell_t warp_cell(input logic [DistW-1:0] dist_val);
    cell_t            c;
    int unsigned      rows;
    int unsigned      cols;
    int unsigned      pos;
    logic [CostW-1:0] up_c;
    logic [LenW-1:0]  up_l;
    logic [CostW:0]   sum;
    logic             take_up;
    logic             row_end;
    rows = fit_size(32'(rows_reg), MAX_ROWS);
    cols = fit_size(32'(cols_reg), MAX_COLS);
    if (col_pos == 0) begin
      diag_c = prev_cost_row[0];
      diag_l = prev_len_row[0];
      prev_cost_row[0] = CostInf;
      prev_len_row[0]  = LenOne;
      left_c = CostInf;
      left_l = LenOne;
    end
    pos  = col_pos + 1;
    up_c = prev_cost_row[pos];
    up_l = prev_len_row[pos];
    if (tie_up) take_up = (up_c <= left_c) && (up_c <= diag_c);
    else        take_up = (up_c < left_c) && (up_c < diag_c);
    if (take_up) begin
      c.dir  = DIR_UP;
      c.cost = up_c;
      c.len  = len_step(up_l, LenOne);
    end else if (diag_c <= left_c && diag_c <= up_c) begin
      c.dir  = DIR_DIAG;
      c.cost = diag_c;
      c.len  = len_step(diag_l, LenW'(diag_step));
    end else begin
      c.dir  = DIR_LEFT;
      c.cost = left_c;
      c.len  = len_step(left_l, LenOne);
    end
    // infinite boundary stays infinite
    sum    = {1'b0, c.cost} + (CostW+1)'(dist_val);
    c.cost = sum[CostW] ? CostInf : sum[CostW-1:0];
    diag_c = up_c;
    diag_l = up_l;
    prev_cost_row[pos] = c.cost;
    prev_len_row[pos]  = c.len;
    left_c = c.cost;
    left_l = c.len;
    row_end = (col_pos + 1 >= cols);
    c.fin   = row_end && (row_pos + 1 >= rows);
    c.norm  = '0;
    if (c.fin) c.norm = (c.len == '0) ? CostInf : c.cost / CostW'(c.len);
    if (c.fin) begin
      new_matrix();
    end else if (row_end) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    return c;
  endfunction

  function automatic int unsigned field_miss(input string what, input logic [CostW-1:0] want,
                                             input logic [CostW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cell_t want;
    cell_t got;
    if (!rst_ni) begin
      rows_reg  = RowCountRst;
      cols_reg  = ColCountRst;
      diag_step = DiagStepRst;
      tie_up    = TieModeRst;
      new_matrix();
      cells_due.delete();
      misses = 0;
      fail_count_o <= 0;
      cells_due_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_ROW_COUNT: rows_reg  = cfg_wdata_i[RowCountW-1:0];
          CFG_COL_COUNT: cols_reg  = cfg_wdata_i[ColCountW-1:0];
          CFG_DIAG_STEP: diag_step = cfg_wdata_i[DiagStepW-1:0];
          CFG_TIE_MODE:  tie_up    = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) cells_due.push_back(warp_cell(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.dir  = dir_e'(m_axis_tdata_i[DirLsb +: 2]);
        got.cost = m_axis_tdata_i[CostLsb +: CostW];
        got.len  = m_axis_tdata_i[LenLsb +: LenW];
        got.fin  = m_axis_tlast_i;
        got.norm = m_axis_tdata_i[NormLsb +: CostW];
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_axis_tdata_i);
          misses++;
        end else begin
          want = cells_due.pop_front();
          misses += field_miss("direction", CostW'(want.dir), CostW'(got.dir));
          misses += field_miss("cell_cost", want.cost, got.cost);
          misses += field_miss("cell_length", CostW'(want.len), CostW'(got.len));
          misses += field_miss("is_final", CostW'(want.fin), CostW'(got.fin));
          misses += field_miss("normalized_cost", want.norm, got.norm);
        end
      end
      fail_count_o <= misses;
      cells_due_o  <= cells_due.size();
    end
  end

endmodule

[tb/dtw_length_normalized_core_tb.sv]
module dtw_length_normalized_core_tb;
  import dtw_ln_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned SmallItems  = 370;
  localparam int unsigned WideItems   = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgAddrW-1:0]  cfg_addr;
  logic [CfgDataW-1:0]  cfg_wdata;
  logic                 src_valid;
  logic                 src_ready;
  logic [InTdataW-1:0]  src_data;
  logic                 res_valid;
  logic                 res_ready;
  logic [OutTdataW-1:0] res_data;
  logic                 res_last;

  int unsigned fail_count;
  int unsigned cells_due;
  int unsigned cycle_count;
  int unsigned hold_asks;
  logic        src_burst;

  dtw_length_normalized_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .s_axis_tdata_i  (src_data),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tlast_o  (res_last)
  );

  dtw_length_normalized_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_i (src_ready),
    .s_axis_tdata_i  (src_data),
    .m_axis_tvalid_i (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_i  (res_data),
    .m_axis_tlast_i  (res_last),
    .fail_count_o    (fail_count),
    .cells_due_o     (cells_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random back-pressure, plus long hold-offs on request
  initial begin : sink
    int unsigned holds_served;
    int unsigned quiet;
    int unsigned mode;
    int unsigned mode_left;
    holds_served = 0;
    quiet        = 0;
    mode         = 0;
    mode_left    = 0;
    res_ready    = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (quiet > 0) begin
        quiet--;
        res_ready <= 1'b0;
      end else if (hold_asks != holds_served) begin
        holds_served++;
        quiet = 400;
        res_ready <= 1'b0;
      end else begin
        case (mode)
          0: res_ready <= 1'b1;
          1: res_ready <= ($urandom_range(0, 3) != 0);
          2: res_ready <= ($urandom_range(0, 2) == 0);
          default: begin
            if ($urandom_range(0, 40) == 0) begin
              quiet = $urandom_range(10, 60);
              res_ready <= 1'b0;
            end else begin
              res_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // unused upper data bits carry noise
  task automatic configure(input logic [RowCountW-1:0] rows, input logic [ColCountW-1:0] cols,
                           input logic [DiagStepW-1:0] step, input logic tie);
    logic [CfgDataW-1:0] noise;
    noise = CfgDataW'($urandom);
    write_reg(CFG_ROW_COUNT, {noise[CfgDataW-1:RowCountW], rows});
    write_reg(CFG_COL_COUNT, cols);
    write_reg(CFG_DIAG_STEP, {noise[CfgDataW-1:DiagStepW], step});
    write_reg(CFG_TIE_MODE, {noise[CfgDataW-1:1], tie});
    cfg_we <= 1'b0;
  endtask

  task automatic push_cell(input logic [DistW-1:0] dist_val);
    int unsigned gap;
    int unsigned r;
    src_valid <= 1'b1;
    src_data  <= dist_val;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    r = $urandom_range(0, 99);
    if (src_burst || r < 60) gap = 0;
    else if (r < 92)         gap = $urandom_range(1, 3);
    else                     gap = $urandom_range(5, 40);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_cells(input int unsigned count, input int unsigned pattern);
    logic [DistW-1:0] level;
    logic [DistW-1:0] d;
    level = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : DistW'($urandom);
    for (int unsigned k = 0; k < count; k++) begin
      case (pattern)
        0: d = DistW'($urandom);
        1: d = DistW'($urandom_range(0, 15));
        2: d = level;
        3: d = $urandom_range(0, 1) ? '1 : '0;
        default: d = level ^ DistW'($urandom_range(0, 3));
      endcase
      push_cell(d);
    end
  endtask

  // sender pauses until every result is back
  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (cells_due != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [DistW-1:0] corner [6];
    int unsigned      rows;
    int unsigned      cols;
    int unsigned      eff;
    int unsigned      count;
    int unsigned      small_items;
    logic             asked;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    src_valid = 1'b0;
    src_data  = '0;
    src_burst = 1'b0;
    hold_asks = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape is a single cell
    push_cell('0);
    push_cell('1);
    drain();

    configure(2, 3, 0, 1'b0);
    corner = '{16'h0000, 16'hffff, 16'h0001, 16'hffff, 16'h0000, 16'h0000};
    foreach (corner[k]) push_cell(corner[k]);
    drain();

    // ties, both modes
    configure(2, 2, 15, 1'b1);
    run_cells(4, 2);
    drain();
    configure(2, 2, 15, 1'b0);
    run_cells(4, 2);
    drain();

    // shape shrinks part way through a matrix
    configure(3, 5, 3, 1'b1);
    run_cells(6, 0);
    drain();
    configure(2, 2, 3, 1'b1);
    run_cells(3, 0);
    drain();

    // zero sizes act as one
    configure(0, 0, 1, 1'b1);
    push_cell(16'h1234);
    drain();

    // oversize width, row cut short; long hold fills the pipe
    configure(1, ColCountW'(MaxColsDef + $urandom_range(1, 1023)),
              DiagStepW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    hold_asks <= hold_asks + 1;
    src_burst = 1'b1;
    run_cells(WideItems, 0);
    src_burst = 1'b0;
    drain();

    // oversize height clamps to the maximum; the first row ends at once
    configure(RowCountW'(MaxRowsDef + $urandom_range(1, 255)), 1,
              DiagStepW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    run_cells(MaxRowsDef, $urandom_range(0, 4));
    drain();

    small_items = 0;
    asked       = 1'b0;
    while (small_items < SmallItems) begin
      case ($urandom_range(0, 9))
        0:       rows = 0;
        1:       rows = $urandom_range(7, 16);
        default: rows = $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 9))
        0:       cols = 0;
        1:       cols = $urandom_range(9, 40);
        default: cols = $urandom_range(1, 8);
      endcase
      configure(RowCountW'(rows), ColCountW'(cols), DiagStepW'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)));
      eff = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
      src_burst = ($urandom_range(0, 4) == 0);
      if (!asked && small_items > SmallItems / 2) begin
        hold_asks <= hold_asks + 1;
        asked = 1'b1;
      end
      repeat ($urandom_range(1, 3)) begin
        // now and then a matrix is cut short and the next shape lands mid-matrix
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, eff) : eff;
        run_cells(count, $urandom_range(0, 4));
        small_items += count;
      end
      drain();
    end
    src_burst = 1'b0;

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && cells_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
